### hw/rtl/stereo_peak_limiter_soft_clip_assert.svh
// Assertion macros for the stereo peak limiter.
`ifndef STEREO_PEAK_LIMITER_SOFT_CLIP_ASSERT_SVH
`define STEREO_PEAK_LIMITER_SOFT_CLIP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SPLSC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SPLSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/splsc_pkg.sv
// Package: types, constants and tanh table builder for the stereo peak limiter.
`default_nettype none
package splsc_pkg;

   localparam int TanhDepthDefault = 256;

   localparam int MagW  = 28;
   localparam int GainW = 25;
   localparam int LvlW  = 23;
   localparam int SampW = 24;
   localparam int RelW  = 24;
   localparam int AmtW  = 17;
   localparam int AccW  = 53;

   localparam logic [GainW-1:0] UnityGain    = 25'd16777216;
   localparam logic [LvlW-1:0]  MinThreshold = 23'd84;
   localparam logic [AmtW-1:0]  FullAmount   = 17'd65536;
   localparam logic [LvlW-1:0]  CeilingReset = 23'd8388607;
   localparam logic [RelW-1:0]  ReleaseReset = 24'd3495;

   typedef enum logic [1:0] {
      CSR_CEILING,
      CSR_THRESHOLD,
      CSR_RELEASE,
      CSR_AMOUNT
   } splsc_csr_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TGT, ST_TDIV, ST_GSEL, ST_RMUL, ST_RFIN, ST_METER,
      ST_SMUL, ST_SFIN, ST_SCHK, ST_PDIV, ST_TLO, ST_THI, ST_ISET,
      ST_IMUL, ST_IFIN, ST_CSET, ST_CMUL, ST_CFIN, ST_B1MUL, ST_B2SET,
      ST_B2MUL, ST_BFIN, ST_CLAMP, ST_DONE
   } splsc_state_type;

   typedef struct packed {
      logic signed [MagW-1:0] left_in;
      logic signed [MagW-1:0] right_in;
      logic                   clear_meter;
   } splsc_req_type;

   typedef struct packed {
      logic signed [SampW-1:0] left_out;
      logic signed [SampW-1:0] right_out;
      logic [GainW-1:0]        applied_gain;
      logic [GainW-1:0]        held_min_gain;
      logic                    clip_warning;
   } splsc_rsp_type;

   // Elaboration-time restoring division, used only to build the table.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r    = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // tanh at entry idx, Q0.24; built from exp(-2u) in Q0.30.
   function automatic logic [GainW-1:0] tanh_entry(input int depth, input int idx);
      logic [63:0] one;
      logic [63:0] a;
      logic [63:0] term;
      logic [63:0] plus;
      logic [63:0] minus;
      logic [63:0] r;
      logic [63:0] p;
      logic [63:0] den;
      logic [63:0] v;
      one   = 64'd1 << 30;
      a     = udiv64(64'd16 << 30, 64'(depth));
      term  = one;
      plus  = one;
      minus = '0;
      for (int k = 1; k <= 24; k++) begin
         den  = 64'(k) << 30;
         term = udiv64(term * a + (den >> 1), den);
         if (k % 2 == 1) minus = minus + term;
         else            plus  = plus + term;
      end
      r = (plus > minus) ? plus - minus : 64'd0;
      if (r > one) r = one;
      p = one;
      for (int i = 0; i < idx; i++) begin
         p = (p * r + (one >> 1)) >> 30;
         if (p > one) p = one;
      end
      den = one + p;
      v   = udiv64(((one - p) << 24) + (den >> 1), den);
      return v[GainW-1:0];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/stereo_peak_limiter_soft_clip.sv
// Top level: stereo peak limiter with tanh soft clip and gain meter.
`default_nettype none
`include "stereo_peak_limiter_soft_clip_assert.svh"
// Stereo brickwall peak limiter. Each req beat carries a Q5.23 stereo pair; one rsp beat
// returns the limited Q1.23 pair, the applied Q1.24 gain, the held minimum gain and the
// sticky warning flag. The gain falls to threshold/peak at once and releases toward unity
// by the release fraction of its distance to unity. Both samples are scaled, blended
// with a table-interpolated tanh soft clip scaled by the ceiling, and clamped to the
// ceiling. All arithmetic runs bit-serially through one shift-add multiplier (one
// multiplier bit per cycle) and one restoring divider (one quotient bit per cycle).
// The tanh lookup and blend are skipped when the amount setting is zero. One item is
// in flight at a time; a finished result waits in the rsp register while the next
// beat is taken. Configuration is written through the csr port; the user must write
// it only while the block is idle, which the block itself does not enforce.
module stereo_peak_limiter_soft_clip
   import splsc_pkg::*;
#(
   parameter int TANH_TABLE_DEPTH = TanhDepthDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire splsc_req_type req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      splsc_rsp_type rsp_data,
   input  wire logic          csr_wr_en,
   input  wire logic [1:0]    csr_index,
   input  wire logic [23:0]   csr_wdata
);

   localparam int IdxW  = $clog2(TANH_TABLE_DEPTH);
   localparam int TabAw = $clog2(TANH_TABLE_DEPTH + 1);
   localparam int QuoW  = IdxW + 16;
   localparam int QMax  = (QuoW > 24) ? QuoW : 24;
   localparam int NMax  = (QMax > 25) ? QMax : 25;
   localparam int CntW  = $clog2(NMax + 1);
   localparam int SdW   = MagW + TabAw;

   // Constant tanh table, one entry past the end for interpolation.
   logic [GainW-1:0] tab_rom [0:TANH_TABLE_DEPTH];
   for (genvar gi = 0; gi <= TANH_TABLE_DEPTH; gi++) begin : g_tab
      localparam logic [GainW-1:0] TabVal = tanh_entry(TANH_TABLE_DEPTH, gi);
      assign tab_rom[gi] = TabVal;
   end

   // Control state
   splsc_state_type state_ff, state_in;
   logic [LvlW-1:0]  ceil_ff, ceil_in;
   logic [LvlW-1:0]  thr_ff, thr_in;
   logic [RelW-1:0]  rel_ff, rel_in;
   logic [AmtW-1:0]  amt_ff, amt_in;
   logic [GainW-1:0] gain_ff, gain_in;
   logic [GainW-1:0] minhold_ff, minhold_in;
   logic             warn_ff, warn_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload and datapath
   logic [MagW-1:0]  lmag_ff, lmag_in, rmag_ff, rmag_in;
   logic             lneg_ff, lneg_in, rneg_ff, rneg_in;
   logic             ch_ff, ch_in;
   logic [GainW-1:0] tgt_ff, tgt_in;
   logic [AccW-1:0]  acc_ff, acc_in, mula_ff, mula_in;
   logic [GainW-1:0] mulb_ff, mulb_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [MagW-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [QMax-1:0]  num_ff, num_in, quo_ff, quo_in;
   logic [MagW-1:0]  s_ff, s_in, res_ff, res_in;
   logic [GainW-1:0] tlo_ff, tlo_in, thi_ff, thi_in, tval_ff, tval_in;
   logic [LvlW-1:0]  cm_ff, cm_in;
   logic [SampW-1:0] lout_ff, lout_in, rout_ff, rout_in;
   splsc_rsp_type    rsp_data_ff, rsp_data_in;

   // Effective settings
   logic [LvlW-1:0]  ceil_eff, thr_lo, thr_eff;
   logic [AmtW-1:0]  amt_eff;
   logic [MagW-1:0]  mag_max, in_lmag, in_rmag;
   logic [AccW-1:0]  mul_sum;
   logic [MagW:0]    div_trial;
   logic             div_ge;
   logic [MagW-1:0]  div_rem;
   logic [QMax-1:0]  quo_next;
   logic             cnt_last;
   logic             s_big;
   logic [SdW-1:0]   sd;
   logic [TabAw-1:0] tab_addr;
   logic [GainW-1:0] tab_q;
   logic [AccW-1:0]  acc_r24, acc_r16, acc_rel;
   logic [GainW:0]   rel_sum;
   logic [GainW-1:0] rel_gain;
   logic [MagW-1:0]  clamp_mag;
   logic [SampW-1:0] clamp_out;
   logic             in_mul, in_div;

   assign ceil_eff = (ceil_ff == '0) ? LvlW'(1) : ceil_ff;
   assign thr_lo   = (thr_ff < MinThreshold) ? MinThreshold : thr_ff;
   assign thr_eff  = (thr_lo > ceil_eff) ? ceil_eff : thr_lo;
   assign amt_eff  = (amt_ff > FullAmount) ? FullAmount : amt_ff;

   // Sign and magnitude of the incoming pair; -2^27 maps to 2^27.
   assign in_lmag = req_data.left_in[MagW-1]  ? MagW'(~req_data.left_in + 1'b1)
                                               : MagW'(req_data.left_in);
   assign in_rmag = req_data.right_in[MagW-1] ? MagW'(~req_data.right_in + 1'b1)
                                               : MagW'(req_data.right_in);
   assign mag_max = (lmag_ff > rmag_ff) ? lmag_ff : rmag_ff;

   // Shift-add multiplier step, restoring divider step
   assign in_mul = (state_ff inside {ST_RMUL, ST_SMUL, ST_IMUL, ST_CMUL, ST_B1MUL,
                                     ST_B2MUL});
   assign in_div = (state_ff inside {ST_TDIV, ST_PDIV});
   assign mul_sum   = acc_ff + (mulb_ff[0] ? mula_ff : '0);
   assign div_trial = {rem_ff, num_ff[QMax-1]};
   assign div_ge    = (div_trial >= {1'b0, den_ff});
   assign div_rem   = div_ge ? MagW'(div_trial - {1'b0, den_ff}) : MagW'(div_trial);
   assign quo_next  = {quo_ff[QMax-2:0], div_ge};
   assign cnt_last  = (cnt_ff == CntW'(1));

   // Soft clip position: s * DEPTH * 2^16 / (8 * C)
   assign s_big = (s_ff >= MagW'({ceil_eff, 3'b000}));
   assign sd    = SdW'(s_ff) * SdW'(TANH_TABLE_DEPTH);

   assign tab_addr = (state_ff == ST_THI) ? TabAw'(quo_ff[QuoW-1:16]) + TabAw'(1)
                                          : TabAw'(quo_ff[QuoW-1:16]);
   assign tab_q    = tab_rom[tab_addr];

   assign acc_r24 = (acc_ff + AccW'(24'h800000)) >> 24;
   assign acc_r16 = (acc_ff + AccW'(16'h8000)) >> 16;
   // Release increment rounds up so the gain reaches unity for any nonzero release.
   assign acc_rel = (acc_ff + AccW'(UnityGain - 1'b1)) >> 24;
   assign rel_sum = {1'b0, gain_ff} + (GainW + 1)'(acc_rel);
   always_comb begin
      rel_gain = (rel_sum > (GainW + 1)'(UnityGain)) ? UnityGain : rel_sum[GainW-1:0];
      if (rel_gain < tgt_ff) rel_gain = tgt_ff;
   end

   assign clamp_mag = (res_ff > MagW'(ceil_eff)) ? MagW'(ceil_eff) : res_ff;
   assign clamp_out = (ch_ff ? rneg_ff : lneg_ff) ? SampW'(~clamp_mag + 1'b1)
                                                  : SampW'(clamp_mag);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_TGT;
         ST_TGT:    state_in = (mag_max > MagW'(thr_eff)) ? ST_TDIV : ST_GSEL;
         ST_TDIV:   if (cnt_last) state_in = ST_GSEL;
         ST_GSEL:   state_in = (tgt_ff < gain_ff) ? ST_METER : ST_RMUL;
         ST_RMUL:   if (cnt_last) state_in = ST_RFIN;
         ST_RFIN:   state_in = ST_METER;
         ST_METER:  state_in = ST_SMUL;
         ST_SMUL:   if (cnt_last) state_in = ST_SFIN;
         ST_SFIN:   state_in = ST_SCHK;
         ST_SCHK: begin
            if (amt_eff == '0)  state_in = ST_CLAMP;
            else if (s_big)     state_in = ST_CSET;
            else                state_in = ST_PDIV;
         end
         ST_PDIV:   if (cnt_last) state_in = ST_TLO;
         ST_TLO:    state_in = ST_THI;
         ST_THI:    state_in = ST_ISET;
         ST_ISET:   state_in = (thi_ff > tlo_ff) ? ST_IMUL : ST_CSET;
         ST_IMUL:   if (cnt_last) state_in = ST_IFIN;
         ST_IFIN:   state_in = ST_CSET;
         ST_CSET:   state_in = ST_CMUL;
         ST_CMUL:   if (cnt_last) state_in = ST_CFIN;
         ST_CFIN:   state_in = ST_B1MUL;
         ST_B1MUL:  if (cnt_last) state_in = ST_B2SET;
         ST_B2SET:  state_in = ST_B2MUL;
         ST_B2MUL:  if (cnt_last) state_in = ST_BFIN;
         ST_BFIN:   state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ch_ff ? ST_DONE : ST_SMUL;
         ST_DONE:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      ceil_in      = ceil_ff;
      thr_in       = thr_ff;
      rel_in       = rel_ff;
      amt_in       = amt_ff;
      gain_in      = gain_ff;
      minhold_in   = minhold_ff;
      warn_in      = warn_ff;
      rsp_valid_in = rsp_valid_ff;
      lmag_in      = lmag_ff;
      rmag_in      = rmag_ff;
      lneg_in      = lneg_ff;
      rneg_in      = rneg_ff;
      ch_in        = ch_ff;
      tgt_in       = tgt_ff;
      acc_in       = acc_ff;
      mula_in      = mula_ff;
      mulb_in      = mulb_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      s_in         = s_ff;
      res_in       = res_ff;
      tlo_in       = tlo_ff;
      thi_in       = thi_ff;
      tval_in      = tval_ff;
      cm_in        = cm_ff;
      lout_in      = lout_ff;
      rout_in      = rout_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         case (splsc_csr_type'(csr_index))
            CSR_CEILING:   ceil_in = csr_wdata[LvlW-1:0];
            CSR_THRESHOLD: thr_in  = csr_wdata[LvlW-1:0];
            CSR_RELEASE:   rel_in  = csr_wdata[RelW-1:0];
            CSR_AMOUNT:    amt_in  = csr_wdata[AmtW-1:0];
            default:       ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      // Advance the shared units
      if (in_mul) begin
         acc_in  = mul_sum;
         mula_in = mula_ff << 1;
         mulb_in = mulb_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
      end
      if (in_div) begin
         rem_in = div_rem;
         num_in = num_ff << 1;
         quo_in = quo_next;
         cnt_in = cnt_ff - 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lmag_in = in_lmag;
               rmag_in = in_rmag;
               lneg_in = req_data.left_in[MagW-1];
               rneg_in = req_data.right_in[MagW-1];
               ch_in   = 1'b0;
               if (req_data.clear_meter) begin
                  minhold_in = UnityGain;
                  warn_in    = 1'b0;
               end
            end
         end
         ST_TGT: begin
            // T < M, so the 24 quotient bits of (T << 24) / M start from T.
            tgt_in = UnityGain;
            rem_in = MagW'(thr_eff);
            den_in = mag_max;
            num_in = '0;
            quo_in = '0;
            cnt_in = CntW'(24);
         end
         ST_TDIV: if (cnt_last) tgt_in = GainW'(quo_next[23:0]);
         ST_GSEL: begin
            if (tgt_ff < gain_ff) begin
               gain_in = tgt_ff;
            end else begin
               acc_in  = '0;
               mula_in = AccW'(UnityGain - gain_ff);
               mulb_in = GainW'(rel_ff);
               cnt_in  = CntW'(RelW);
            end
         end
         ST_RFIN: gain_in = rel_gain;
         ST_METER: begin
            if (gain_ff < minhold_ff) minhold_in = gain_ff;
            if (gain_ff < UnityGain)  warn_in    = 1'b1;
            acc_in  = '0;
            mula_in = AccW'(lmag_ff);
            mulb_in = gain_ff;
            cnt_in  = CntW'(GainW);
         end
         ST_SFIN: s_in = MagW'(acc_r24);
         ST_SCHK: begin
            res_in  = s_ff;
            tval_in = UnityGain;
            rem_in  = MagW'(sd >> IdxW);
            num_in  = QMax'({sd[IdxW-1:0], 16'h0000}) << (QMax - QuoW);
            den_in  = MagW'({ceil_eff, 3'b000});
            quo_in  = '0;
            cnt_in  = CntW'(QuoW);
         end
         ST_TLO: tlo_in = tab_q;
         ST_THI: thi_in = tab_q;
         ST_ISET: begin
            tval_in = tlo_ff;
            acc_in  = '0;
            mula_in = AccW'(thi_ff - tlo_ff);
            mulb_in = GainW'(quo_ff[15:0]);
            cnt_in  = CntW'(16);
         end
         ST_IFIN: tval_in = tlo_ff + GainW'(acc_r16);
         ST_CSET: begin
            acc_in  = '0;
            mula_in = AccW'(ceil_eff);
            mulb_in = tval_ff;
            cnt_in  = CntW'(GainW);
         end
         ST_CFIN: begin
            cm_in   = LvlW'(acc_r24);
            acc_in  = '0;
            mula_in = AccW'(s_ff);
            mulb_in = GainW'(FullAmount - amt_eff);
            cnt_in  = CntW'(AmtW);
         end
         ST_B2SET: begin
            // Keep the accumulator: second term adds onto the first.
            mula_in = AccW'(cm_ff);
            mulb_in = GainW'(amt_eff);
            cnt_in  = CntW'(AmtW);
         end
         ST_BFIN: res_in = MagW'(acc_r16);
         ST_CLAMP: begin
            if (ch_ff) begin
               rout_in = clamp_out;
            end else begin
               lout_in = clamp_out;
               ch_in   = 1'b1;
               acc_in  = '0;
               mula_in = AccW'(rmag_ff);
               mulb_in = gain_ff;
               cnt_in  = CntW'(GainW);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.left_out       = lout_ff;
               rsp_data_in.right_out      = rout_ff;
               rsp_data_in.applied_gain   = gain_ff;
               rsp_data_in.held_min_gain  = minhold_ff;
               rsp_data_in.clip_warning   = warn_ff;
            end
         end
         default: ;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ceil_ff      <= CeilingReset;
         thr_ff       <= CeilingReset;
         rel_ff       <= ReleaseReset;
         amt_ff       <= '0;
         gain_ff      <= UnityGain;
         minhold_ff   <= UnityGain;
         warn_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ceil_ff      <= ceil_in;
         thr_ff       <= thr_in;
         rel_ff       <= rel_in;
         amt_ff       <= amt_in;
         gain_ff      <= gain_in;
         minhold_ff   <= minhold_in;
         warn_ff      <= warn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lmag_ff     <= lmag_in;
      rmag_ff     <= rmag_in;
      lneg_ff     <= lneg_in;
      rneg_ff     <= rneg_in;
      ch_ff       <= ch_in;
      tgt_ff      <= tgt_in;
      acc_ff      <= acc_in;
      mula_ff     <= mula_in;
      mulb_ff     <= mulb_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      s_ff        <= s_in;
      res_ff      <= res_in;
      tlo_ff      <= tlo_in;
      thi_ff      <= thi_in;
      tval_ff     <= tval_in;
      cm_ff       <= cm_in;
      lout_ff     <= lout_in;
      rout_ff     <= rout_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   `SPLSC_ASSERT_SAME(a_gain_unity, clock, reset, rsp_valid_ff,
      rsp_data_ff.applied_gain <= UnityGain, "applied gain above unity")
   `SPLSC_ASSERT_SAME(a_hold_min, clock, reset, rsp_valid_ff,
      rsp_data_ff.held_min_gain <= rsp_data_ff.applied_gain, "held gain above applied")
   `SPLSC_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready,
      !req_ready, "beat taken while an item is in flight")

endmodule
`default_nettype wire

### test/stereo_peak_limiter_soft_clip_checker.sv
// Checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
module stereo_peak_limiter_soft_clip_checker
   import splsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_ready,
   input  splsc_req_type req_data,
   input  logic          rsp_valid,
   input  logic          rsp_ready,
   input  splsc_rsp_type rsp_data,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [23:0]   csr_wdata,
   output int            fail_count,
   output int            pending_count,
   output int            rsp_count
);
   localparam int Depth = TanhDepthDefault;
   localparam logic [63:0] Unity = 64'd16777216;
   localparam logic [63:0] OneQ30 = 64'd1 << 30;

   logic [63:0] tanh_lut [0:Depth];
   logic [63:0] ceil_q, thresh_q, rel_q, amt_q;
   logic [63:0] gain_q, min_hold_q, warn_q;
   splsc_rsp_type expected_rsps [$];

   initial begin
      logic [63:0] a, term, plus, minus, r, p, den;
      a = (64'd16 * OneQ30) / Depth;
      term = OneQ30; plus = OneQ30; minus = 0; p = OneQ30;
      for (int k = 1; k <= 24; k++) begin
         den = 64'(k) * OneQ30;
         term = (term * a + den / 2) / den;
         if (k % 2 == 1) minus += term; else plus += term;
      end
      r = (plus > minus) ? plus - minus : 0;
      if (r > OneQ30) r = OneQ30;
      for (int i = 0; i <= Depth; i++) begin
         den = OneQ30 + p;
         tanh_lut[i] = (((OneQ30 - p) << 24) + den / 2) / den;
         p = (p * r + OneQ30 / 2) >> 30;
         if (p > OneQ30) p = OneQ30;
      end
   end

   // Scale one magnitude by the gain, blend the soft clip, clamp to the ceiling.
   function automatic logic [63:0] limit_mag(logic [63:0] mag, logic [63:0] g,
                                             logic [63:0] c, logic [63:0] amt);
      logic [63:0] s, out, pos, idx, frac, t, cm;
      s = (mag * g + Unity / 2) >> 24;
      out = s;
      if (amt != 0) begin
         pos = ((s * Depth) << 16) / (8 * c);
         idx = pos >> 16;
         frac = pos & 64'hFFFF;
         if (idx >= Depth) t = Unity;
         else begin
            t = tanh_lut[idx];
            if (tanh_lut[idx+1] > t) t += ((tanh_lut[idx+1] - t) * frac + 32768) >> 16;
         end
         cm = (c * t + Unity / 2) >> 24;
         out = (s * (64'd65536 - amt) + cm * amt + 32768) >> 16;
      end
      if (out > c) out = c;
      return out;
   endfunction

   function automatic splsc_rsp_type predict_limited(splsc_req_type rq);
      logic [63:0] lm, rm, m, c, t, amt, tgt, g, lo, ro;
      logic ln, rn;
      splsc_rsp_type rs;
      ln = rq.left_in[27];
      rn = rq.right_in[27];
      lm = ln ? 64'(-rq.left_in) & 64'hFFFFFFF : 64'(rq.left_in);
      rm = rn ? 64'(-rq.right_in) & 64'hFFFFFFF : 64'(rq.right_in);
      if (ln && lm == 0) lm = 64'h8000000;
      if (rn && rm == 0) rm = 64'h8000000;
      if (rq.clear_meter) begin
         min_hold_q = Unity;
         warn_q = 0;
      end
      c = ceil_q != 0 ? ceil_q : 1;
      t = thresh_q < 84 ? 84 : thresh_q;
      if (t > c) t = c;
      amt = amt_q > 65536 ? 65536 : amt_q;
      m = lm > rm ? lm : rm;
      tgt = m > t ? (t << 24) / m : Unity;
      g = gain_q;
      if (tgt < g) g = tgt;
      else begin
         g += ((Unity - g) * rel_q + (Unity - 1)) >> 24;
         if (g > Unity) g = Unity;
         if (g < tgt) g = tgt;
      end
      gain_q = g;
      lo = limit_mag(lm, g, c, amt);
      ro = limit_mag(rm, g, c, amt);
      if (g < min_hold_q) min_hold_q = g;
      if (g < Unity) warn_q = 1;
      rs.left_out = ln ? -lo[23:0] : lo[23:0];
      rs.right_out = rn ? -ro[23:0] : ro[23:0];
      rs.applied_gain = g[24:0];
      rs.held_min_gain = min_hold_q[24:0];
      rs.clip_warning = warn_q[0];
      return rs;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      splsc_rsp_type want;
      if (reset) begin
         ceil_q <= 8388607; thresh_q <= 8388607; rel_q <= 3495; amt_q <= 0;
         gain_q <= Unity; min_hold_q <= Unity; warn_q <= 0;
         expected_rsps.delete();
         fail_count <= 0;
         rsp_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (splsc_csr_type'(csr_index))
               CSR_CEILING:   ceil_q <= 64'(csr_wdata[22:0]);
               CSR_THRESHOLD: thresh_q <= 64'(csr_wdata[22:0]);
               CSR_RELEASE:   rel_q <= 64'(csr_wdata);
               CSR_AMOUNT:    amt_q <= 64'(csr_wdata[16:0]);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               $error("unexpected result beat %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want != rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (want.left_out != rsp_data.left_out)
                     $error("left_out exp %0d got %0d", want.left_out, rsp_data.left_out);
                  if (want.right_out != rsp_data.right_out)
                     $error("right_out exp %0d got %0d", want.right_out, rsp_data.right_out);
                  if (want.applied_gain != rsp_data.applied_gain)
                     $error("applied_gain exp %0d got %0d", want.applied_gain,
                            rsp_data.applied_gain);
                  if (want.held_min_gain != rsp_data.held_min_gain)
                     $error("held_min_gain exp %0d got %0d", want.held_min_gain,
                            rsp_data.held_min_gain);
                  if (want.clip_warning != rsp_data.clip_warning)
                     $error("clip_warning exp %0b got %0b", want.clip_warning,
                            rsp_data.clip_warning);
               end
            end
         end
         // csr writes happen only while idle, so blocking state use is safe here
         if (req_valid && req_ready) expected_rsps.push_back(predict_limited(req_data));
      end
   end
endmodule

### test/stereo_peak_limiter_soft_clip_tb.sv
// Testbench top: stimulus, configuration phases, watchdog and verdict.
`timescale 1ns / 1ps
module stereo_peak_limiter_soft_clip_tb;
   import splsc_pkg::*;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_ready;
   splsc_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 0;
   splsc_rsp_type rsp_data;
   logic          csr_wr_en = 0;
   logic [1:0]    csr_index = '0;
   logic [23:0]   csr_wdata = '0;
   int            fail_count, pending_count, rsp_count;
   int            sent_count = 0;
   int            idle_cycles = 0;
   bit            hold_rsp = 0;

   localparam int IdleLimit = 200000;

   always #1 clock = ~clock;

   stereo_peak_limiter_soft_clip u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata
   );

   stereo_peak_limiter_soft_clip_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .pending_count, .rsp_count
   );

   // Draw a gap: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // Receiver: random stalls; a long hold-off when asked, counted here.
   always begin
      int gap;
      @(negedge clock);
      if (hold_rsp) begin
         rsp_ready <= 0;
         repeat (2000) @(negedge clock);
         hold_rsp = 0;
      end
      gap = pick_gap();
      if (gap > 0) begin
         rsp_ready <= 0;
         repeat (gap - 1) @(negedge clock);
      end else rsp_ready <= 1;
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("Some tests failed");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   task automatic write_csr(splsc_csr_type idx, logic [23:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // Send one beat, hold it until taken, then an optional gap.
   task automatic send_pair(logic [27:0] l, logic [27:0] r, logic clr, bit gaps);
      int gap;
      req_valid <= 1;
      req_data <= '{left_in: l, right_in: r, clear_meter: clr};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drain results, then let the block settle before touching registers.
   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   function automatic logic [27:0] rand_sample();
      int r;
      r = $urandom_range(9);
      if (r < 3) return 28'($signed($urandom_range(0, 16777215)) - 8388608);
      if (r < 5) return 28'($signed($urandom_range(0, 2097151)) - 1048576);
      if (r < 6) return {$urandom_range(1) ? 4'hF : 4'h0, 24'($urandom)};
      return 28'($urandom);
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: field extremes at reset settings.
      send_pair(28'h7FFFFFF, 28'h8000000, 0, 0);
      send_pair(28'h0, 28'h0, 0, 0);
      send_pair(28'h8000000, 28'h7FFFFFF, 1, 0);
      send_pair(28'h0400000, 28'hFC00000, 0, 0);
      send_pair(28'h0000001, 28'hFFFFFFF, 1, 0);
      drain();

      // Full soft clip, amount above full, zero ceiling, low threshold, no release.
      write_csr(CSR_AMOUNT, 24'd65536);
      write_csr(CSR_CEILING, 24'd4000000);
      write_csr(CSR_THRESHOLD, 24'd2000000);
      send_pair(28'h0300000, 28'h0100000, 0, 0);
      send_pair(28'hFA00000, 28'h0000010, 0, 0);
      send_pair(28'h7FFFFFF, 28'h8000000, 0, 0);
      drain();
      write_csr(CSR_AMOUNT, 24'h1FFFF);
      write_csr(CSR_CEILING, 24'd0);
      write_csr(CSR_THRESHOLD, 24'd0);
      write_csr(CSR_RELEASE, 24'd0);
      send_pair(28'h0000005, 28'h0000000, 0, 0);
      send_pair(28'h0010000, 28'hFFF0000, 0, 0);
      send_pair(28'h0, 28'h0, 1, 0);
      send_pair(28'h0, 28'h0, 0, 0);
      drain();
      write_csr(CSR_RELEASE, 24'hFFFFFF);
      write_csr(CSR_CEILING, 24'h7FFFFF);
      write_csr(CSR_THRESHOLD, 24'h7FFFFF);
      write_csr(CSR_AMOUNT, 24'd1);
      send_pair(28'h1000000, 28'h0, 0, 0);
      send_pair(28'h0, 28'h0, 0, 0);
      send_pair(28'h0123456, 28'hF654321, 1, 0);
      drain();

      // Random phases with fresh settings; the fifth one stalls the receiver long.
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_CEILING, ph == 0 ? 24'd1 : 24'($urandom_range(1, 8388607)));
         write_csr(CSR_THRESHOLD, ph == 1 ? 24'd84 : 24'($urandom_range(84, 8388607)));
         write_csr(CSR_RELEASE, ph == 2 ? 24'd1 : 24'($urandom_range(1, 16777215)));
         write_csr(CSR_AMOUNT, ph == 3 ? 24'd0 : 24'($urandom_range(0, 65536)));
         if (ph == 4) hold_rsp = 1;
         for (int n = 0; n < 142; n++)
            send_pair(rand_sample(), rand_sample(), $urandom_range(15) == 0, 1);
         drain();
      end

      $display("Sent %0d stereo beats over 12 register settings, %0d results checked.",
               sent_count, rsp_count);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
